### rtl/ifhg_pkg.sv
// Shared constants and controller/datapath handshake types for the IPv4
// fragment header generator. No dependencies.
`default_nettype none

package ifhg_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_FRAGMENT_BYTES = 2'd0;
  localparam logic [1:0] REG_MAX_PAYLOAD    = 2'd1;
  localparam logic [1:0] REG_TIME_TO_LIVE   = 2'd2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 14;

  // Reset values of the configuration registers
  localparam logic [10:0] FRAGMENT_BYTES_RST = 11'd1480;
  localparam logic [13:0] MAX_PAYLOAD_RST    = 14'd8872;
  localparam logic [7:0]  TIME_TO_LIVE_RST   = 8'd255;

  localparam logic [13:0] HARD_MAX_PAYLOAD = 14'd8872;
  localparam logic [10:0] FRAG_MAX         = 11'd1480;
  localparam logic [10:0] FRAG_MIN         = 11'd256;
  localparam logic [10:0] IP_HEADER_BYTES  = 11'd20;
  localparam logic [13:0] UDP_HEADER_BYTES = 14'd8;
  localparam logic [15:0] VERSION_IHL_WORD = 16'h4500;
  localparam logic [7:0]  PROTO_UDP        = 8'd17;
  localparam logic [15:0] ID_RST           = 16'd1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture request and effective configuration
    logic sum;        // add the per-datagram header words, take an id
    logic fold;       // fold the per-datagram sum to 16 bits
    logic emit_frag;  // write one fragment result to the output register
    logic emit_err;   // write the oversize result to the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic too_large;  // captured payload exceeds the effective limit
    logic out_free;   // output register can take a result this cycle
    logic last_frag;  // fragment at hand is the final one
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/ifhg_channels.sv
// Valid/ready channel interfaces for send requests and header results.
// No dependencies.
`default_nettype none

interface ifhg_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] source_address;
  logic [31:0] destination_address;
  logic [15:0] payload_length;

  modport source (output valid, source_address, destination_address, payload_length,
                  input ready);
  modport sink (input valid, source_address, destination_address, payload_length,
                output ready);
endinterface

interface ifhg_res_if;
  logic        valid;
  logic        ready;
  logic [12:0] fragment_offset;
  logic        more_fragments;
  logic [10:0] packet_length;
  logic [15:0] identification;
  logic [15:0] header_checksum;
  logic        last;
  logic        too_large;

  modport source (output valid, fragment_offset, more_fragments, packet_length,
                  identification, header_checksum, last, too_large,
                  input ready);
  modport sink (input valid, fragment_offset, more_fragments, packet_length,
                identification, header_checksum, last, too_large,
                output ready);
endinterface

`default_nettype wire

### rtl/ifhg_ctrl.sv
// Sequencing state machine for the fragment header generator.
// Depends on ifhg_pkg.
`default_nettype none

module ifhg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire ifhg_pkg::dp_stat_t stat,
  output ifhg_pkg::ctrl_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_FOLD  = 3'd2;
  localparam logic [2:0] ST_FRAG  = 3'd3;
  localparam logic [2:0] ST_ERR   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.too_large) begin
          state_next = ST_ERR;
        end else begin
          cmd.sum    = 1'b1;
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold   = 1'b1;
        state_next = ST_FRAG;
      end
      ST_FRAG: begin
        if (stat.out_free) begin
          cmd.emit_frag = 1'b1;
          if (stat.last_frag) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (stat.out_free) begin
          cmd.emit_err = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/ifhg_dp.sv
// Datapath: configuration registers, id counter, fragment walk, checksum
// and output register. Depends on ifhg_pkg.
`default_nettype none

module ifhg_dp (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [ifhg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ifhg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic [31:0]                     in_source_address,
  input  wire logic [31:0]                     in_destination_address,
  input  wire logic [15:0]                     in_payload_length,
  input  wire ifhg_pkg::ctrl_cmd_t             cmd,
  output ifhg_pkg::dp_stat_t                   stat,
  input  wire logic                            res_ready,
  output logic                                 res_valid,
  output logic [12:0]                          res_fragment_offset,
  output logic                                 res_more_fragments,
  output logic [10:0]                          res_packet_length,
  output logic [15:0]                          res_identification,
  output logic [15:0]                          res_header_checksum,
  output logic                                 res_last,
  output logic                                 res_too_large
);

  logic [10:0] fragment_bytes;
  logic [13:0] max_payload;
  logic [7:0]  time_to_live;
  logic [15:0] id_counter;

  logic [31:0] src;
  logic [31:0] dst;
  logic [15:0] plen;
  logic [10:0] frag;
  logic [13:0] limit;
  logic [15:0] id;
  logic [18:0] raw_sum;
  logic [15:0] partial;
  logic [13:0] remaining;
  logic [13:0] sent;

  logic [10:0] frag_masked;
  logic [10:0] frag_eff;
  logic [13:0] limit_eff;
  logic [16:0] raw_fold;
  logic        more;
  logic [10:0] chunk;
  logic [10:0] tlen;
  logic [12:0] offset;
  logic [15:0] flagoff;
  logic [17:0] cs_sum;
  logic [16:0] cs_fold;
  logic [15:0] cs_folded;

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      fragment_bytes <= ifhg_pkg::FRAGMENT_BYTES_RST;
      max_payload    <= ifhg_pkg::MAX_PAYLOAD_RST;
      time_to_live   <= ifhg_pkg::TIME_TO_LIVE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ifhg_pkg::REG_FRAGMENT_BYTES: fragment_bytes <= cfg_wdata[10:0];
        ifhg_pkg::REG_MAX_PAYLOAD:    max_payload    <= cfg_wdata;
        ifhg_pkg::REG_TIME_TO_LIVE:   time_to_live   <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Effective fragment size and payload limit
  always_comb begin
    frag_masked = {fragment_bytes[10:3], 3'b000};
    if (frag_masked < ifhg_pkg::FRAG_MIN) begin
      frag_eff = ifhg_pkg::FRAG_MIN;
    end else if (frag_masked > ifhg_pkg::FRAG_MAX) begin
      frag_eff = ifhg_pkg::FRAG_MAX;
    end else begin
      frag_eff = frag_masked;
    end
    limit_eff = (max_payload < ifhg_pkg::HARD_MAX_PAYLOAD) ? max_payload
                                                          : ifhg_pkg::HARD_MAX_PAYLOAD;
  end

  // Per-fragment arithmetic
  always_comb begin
    raw_fold  = {1'b0, raw_sum[15:0]} + 17'(raw_sum[18:16]);
    more      = remaining > 14'(frag);
    chunk     = more ? frag : remaining[10:0];
    tlen      = chunk + ifhg_pkg::IP_HEADER_BYTES;
    offset    = 13'(sent[13:3]);
    flagoff   = {2'b00, more, offset};
    cs_sum    = 18'(partial) + 18'(tlen) + 18'(flagoff);
    cs_fold   = {1'b0, cs_sum[15:0]} + 17'(cs_sum[17:16]);
    cs_folded = cs_fold[15:0] + 16'(cs_fold[16]);
  end

  assign stat.too_large = plen > 16'(limit);
  assign stat.out_free  = !res_valid || res_ready;
  assign stat.last_frag = !more;

  always_ff @(posedge clk) begin
    if (rst) begin
      id_counter <= ifhg_pkg::ID_RST;
    end else if (cmd.sum) begin
      id_counter <= id_counter + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      src   <= in_source_address;
      dst   <= in_destination_address;
      plen  <= in_payload_length;
      frag  <= frag_eff;
      limit <= limit_eff;
    end
    if (cmd.sum) begin
      id        <= id_counter;
      raw_sum   <= 19'(ifhg_pkg::VERSION_IHL_WORD) + 19'(id_counter)
                 + 19'({time_to_live, ifhg_pkg::PROTO_UDP})
                 + 19'(src[31:16]) + 19'(src[15:0])
                 + 19'(dst[31:16]) + 19'(dst[15:0]);
      // Length already checked against a limit below 16384
      remaining <= plen[13:0] + ifhg_pkg::UDP_HEADER_BYTES;
      sent      <= '0;
    end
    if (cmd.fold) begin
      partial <= raw_fold[15:0] + 16'(raw_fold[16]);
    end
    if (cmd.emit_frag) begin
      remaining <= remaining - 14'(chunk);
      sent      <= sent + 14'(chunk);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit_frag || cmd.emit_err) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_frag) begin
      res_fragment_offset <= offset;
      res_more_fragments  <= more;
      res_packet_length   <= tlen;
      res_identification  <= id;
      res_header_checksum <= ~cs_folded;
      res_last            <= !more;
      res_too_large       <= 1'b0;
    end else if (cmd.emit_err) begin
      res_fragment_offset <= '0;
      res_more_fragments  <= 1'b0;
      res_packet_length   <= '0;
      res_identification  <= '0;
      res_header_checksum <= '0;
      res_last            <= 1'b1;
      res_too_large       <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_err_fields_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_too_large |-> res_last && !res_more_fragments
      && res_fragment_offset == 13'd0 && res_packet_length == 11'd0
      && res_identification == 16'd0 && res_header_checksum == 16'd0)
    else $error("oversize result carries nonzero fields");

  a_more_vs_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_too_large |-> res_more_fragments != res_last)
    else $error("more_fragments and last disagree");

  a_full_fragment_len: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_more_fragments |-> res_packet_length == frag + ifhg_pkg::IP_HEADER_BYTES)
    else $error("non-final fragment is not full size");

  a_id_hold: assert property (@(posedge clk) disable iff (rst)
    !rst && !cmd.sum |=> $stable(id_counter))
    else $error("id counter moved outside a datagram start");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_frag || cmd.emit_err |-> stat.out_free)
    else $error("result written over a pending result");
`endif

endmodule

`default_nettype wire

### rtl/ipv4_fragment_header_generator_unit.sv
// Top level of the IPv4 fragment header generator: controller, datapath
// and channel wiring. Depends on ifhg_pkg, ifhg_channels, ifhg_ctrl, ifhg_dp.
`default_nettype none

// Sequence: after the request transfer the controller checks the length,
//   sums and folds the header words, then writes the first header to the
//   output register; an oversize request goes on to its error result.
// Throughput: the fragment walk issues one header per cycle while the output register is free.
// Reset: synchronous, active high; restores the configuration registers,
//   sets the identification counter to 1 and empties the output register.
module ipv4_fragment_header_generator_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  ifhg_req_if.sink                              req,
  ifhg_res_if.source                            res,
  input  wire logic                             cfg_we,
  input  wire logic [ifhg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ifhg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  ifhg_pkg::ctrl_cmd_t cmd;
  ifhg_pkg::dp_stat_t  stat;
  logic                req_ready;

  // Request ready only while the controller is idle; the output register
  // lets a new request in while the last header still waits for transfer.
  assign req.ready = req_ready;

  ifhg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath holds the configuration, the id counter, the fragment walk,
  // the checksum adder and the output register.
  ifhg_dp u_dp (
    .clk                    (clk),
    .rst                    (rst),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_source_address      (req.source_address),
    .in_destination_address (req.destination_address),
    .in_payload_length      (req.payload_length),
    .cmd                    (cmd),
    .stat                   (stat),
    .res_ready              (res.ready),
    .res_valid              (res.valid),
    .res_fragment_offset    (res.fragment_offset),
    .res_more_fragments     (res.more_fragments),
    .res_packet_length      (res.packet_length),
    .res_identification     (res.identification),
    .res_header_checksum    (res.header_checksum),
    .res_last               (res.last),
    .res_too_large          (res.too_large)
  );

endmodule

`default_nettype wire
